### rtl/mrms_pkg.sv
package mrms_pkg;

    localparam int POP       = 1024;
    localparam int POP_W     = $clog2(POP);
    localparam int TDEPTH    = 256;
    localparam int TAB_W     = $clog2(TDEPTH);
    localparam int LEN_W     = 9;
    localparam int FRAC      = 16;
    localparam int FIT_W     = FRAC + 2;
    localparam int GEN_W     = 32;
    localparam int MUT_W     = 16;
    localparam int DRAW_W    = 16;
    localparam int TOTAL_W   = 28;
    localparam int DEN_W     = FRAC + 1;
    localparam int DIV_W     = 2 * FIT_W;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 18;
    localparam int RATE_W    = 17;

    localparam logic [FIT_W-1:0]   ONE       = FIT_W'(1 << FRAC);
    localparam logic [FIT_W-1:0]   FIT_MAX   = '1;
    localparam logic [FIT_W-1:0]   FIT_RST   = FIT_W'(1 << (FRAC - 1));
    localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(POP * (1 << (FRAC - 1)));
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'(POP * ((1 << FIT_W) - 1));

    typedef enum logic [1:0] {
        REQ_STEP      = 2'd0,
        REQ_LOAD_LOW  = 2'd1,
        REQ_LOAD_HIGH = 2'd2,
        REQ_NONE      = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWITCH_THR  = 3'd0,
        CFG_NEUTRAL_LOW = 3'd1,
        CFG_NEUTRAL_HI  = 3'd2,
        CFG_MUT_RATE    = 3'd3,
        CFG_REV_MIN     = 3'd4,
        CFG_LOW_LEN     = 3'd5,
        CFG_HIGH_LEN    = 3'd6,
        CFG_SPARE       = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TARGET,
        ST_WALK,
        ST_PICK,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_TAB_READ,
        ST_EFFECT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIX,
        ST_CHILD_READ,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic             rev;
        logic [MUT_W-1:0] mut;
        logic [GEN_W-1:0] gen;
        logic [FIT_W-1:0] fit;
    } pop_word_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } div_rsp_t;

endpackage

### rtl/mrms_if.sv
interface mrms_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    req_type;
    logic [mrms_pkg::TAB_W-1:0]    table_slot;
    logic [mrms_pkg::FIT_W-1:0]    table_value;
    logic [mrms_pkg::DRAW_W-1:0]   wheel_point;
    logic [mrms_pkg::POP_W-1:0]    child_index;
    logic [mrms_pkg::DRAW_W-1:0]   mutate_draw;
    logic [mrms_pkg::DRAW_W-1:0]   effect_draw;

    modport source (output valid, req_type, table_slot, table_value, wheel_point,
                    child_index, mutate_draw, effect_draw, input ready);
    modport sink (input valid, req_type, table_slot, table_value, wheel_point,
                  child_index, mutate_draw, effect_draw, output ready);
endinterface

interface mrms_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mrms_pkg::POP_W-1:0]    parent_slot;
    logic [mrms_pkg::POP_W-1:0]    child_slot;
    logic [mrms_pkg::FIT_W-1:0]    child_fitness;
    logic                          mutated;
    logic                          became_revertant;
    logic                          child_revertant;
    logic [mrms_pkg::GEN_W-1:0]    child_generation;
    logic [mrms_pkg::MUT_W-1:0]    child_mutations;

    modport source (output valid, parent_slot, child_slot, child_fitness, mutated,
                    became_revertant, child_revertant, child_generation,
                    child_mutations, input ready);
    modport sink (input valid, parent_slot, child_slot, child_fitness, mutated,
                  became_revertant, child_revertant, child_generation,
                  child_mutations, output ready);
endinterface

### rtl/mrms_div.sv
module mrms_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  mrms_pkg::div_req_t req,
    output mrms_pkg::div_rsp_t rsp
);

    logic [mrms_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [mrms_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [mrms_pkg::DEN_W-1:0]     rem_reg, rem_next;
    logic [mrms_pkg::DEN_W-1:0]     den_reg, den_next;
    logic [mrms_pkg::DEN_W:0]       shifted;
    logic                           ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[mrms_pkg::DIV_W-1]};
        ge        = shifted >= {1'b0, den_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            cnt_next  = mrms_pkg::DIV_CNT_W'(mrms_pkg::DIV_W);
            busy_next = 1'b1;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? mrms_pkg::DEN_W'(shifted - {1'b0, den_reg})
                          : mrms_pkg::DEN_W'(shifted);
            quo_next = {quo_reg[mrms_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mrms_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/moran_roulette_mutation_step_core.sv
// One Moran step per step item: roulette parent selection over a 1024-entry population
// memory, optional mutation from a low or high effect table, and write-back over the child
// slot. After reset the block clears the whole population memory before it takes any
// item; configuration writes are taken during that time. A load item is written into
// its table as it is taken. During a step item the input is held while the roulette
// walk reads one population entry per cycle through the single memory read port (up
// to 1024 reads, after the read pipeline fills), then, for a mutating step, the shared
// 36-step divider runs once for the table index and once for the effect, and the child
// entry is read and written back. A result waits in an output register while the next
// item is taken; a step waits to commit while that register is still full.
module moran_roulette_mutation_step_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mrms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrms_pkg::CFG_W-1:0]       cfg_wdata,
    mrms_req_if.sink                         req,
    mrms_rsp_if.source                       rsp
);

    mrms_pkg::state_t state_reg, state_next;

    logic [mrms_pkg::FIT_W-1:0]   switch_thr_reg;
    logic [mrms_pkg::FRAC-1:0]    neutral_low_reg;
    logic [mrms_pkg::FRAC-1:0]    neutral_hi_reg;
    logic [mrms_pkg::RATE_W-1:0]  mut_rate_reg;
    logic [mrms_pkg::FIT_W-1:0]   rev_min_reg;
    logic [mrms_pkg::LEN_W-1:0]   low_len_reg;
    logic [mrms_pkg::LEN_W-1:0]   high_len_reg;

    mrms_pkg::pop_word_t          pop_mem [mrms_pkg::POP];
    mrms_pkg::pop_word_t          pop_rdata_reg;
    logic [mrms_pkg::POP_W-1:0]   pop_raddr;
    logic                         pop_we;
    logic [mrms_pkg::POP_W-1:0]   pop_waddr;
    mrms_pkg::pop_word_t          pop_wdata;

    logic [mrms_pkg::FIT_W-1:0]   lo_mem [mrms_pkg::TDEPTH];
    logic [mrms_pkg::FIT_W-1:0]   hi_mem [mrms_pkg::TDEPTH];
    logic [mrms_pkg::FIT_W-1:0]   lo_rdata_reg;
    logic [mrms_pkg::FIT_W-1:0]   hi_rdata_reg;

    logic [mrms_pkg::POP_W-1:0]   clr_cnt_reg;
    logic [mrms_pkg::TOTAL_W-1:0] total_reg;

    logic [mrms_pkg::DRAW_W-1:0]  wheel_reg;
    logic [mrms_pkg::POP_W-1:0]   child_reg;
    logic [mrms_pkg::DRAW_W-1:0]  mdraw_reg;
    logic [mrms_pkg::DRAW_W-1:0]  edraw_reg;
    logic [mrms_pkg::TOTAL_W-1:0] target_reg;
    logic [mrms_pkg::POP_W-1:0]   walk_addr_reg;
    logic [mrms_pkg::POP_W-1:0]   rd_idx_reg;
    logic                         rd_pend_reg;
    logic [mrms_pkg::TOTAL_W-1:0] cum_reg;
    logic [mrms_pkg::POP_W-1:0]   parent_reg;
    mrms_pkg::pop_word_t          pword_reg;
    logic                         high_reg;
    logic                         mut_flag_reg;
    logic                         down_reg;
    logic                         neg_reg;
    logic [mrms_pkg::DIV_W-1:0]   prod_reg;
    logic [mrms_pkg::DEN_W-1:0]   den_reg;
    logic [mrms_pkg::FIT_W-1:0]   cfit_reg;

    logic                         out_valid_reg;
    logic [mrms_pkg::POP_W-1:0]   out_parent_reg;
    logic [mrms_pkg::POP_W-1:0]   out_child_reg;
    logic [mrms_pkg::FIT_W-1:0]   out_fit_reg;
    logic                         out_mut_reg;
    logic                         out_became_reg;
    logic                         out_rev_reg;
    logic [mrms_pkg::GEN_W-1:0]   out_gen_reg;
    logic [mrms_pkg::MUT_W-1:0]   out_cnt_reg;

    mrms_pkg::div_req_t           div_req;
    mrms_pkg::div_rsp_t           div_rsp;

    logic                         accept;
    logic                         out_blocked;
    logic                         commit;
    logic [mrms_pkg::TOTAL_W-1:0] cum_sum;
    logic                         hit;
    logic                         mutate;
    logic                         high_sel;
    logic [mrms_pkg::LEN_W-1:0]   len_raw;
    logic [mrms_pkg::LEN_W-1:0]   len_clamp;
    logic [mrms_pkg::FIT_W-1:0]   eff;
    logic [mrms_pkg::FIT_W-1:0]   neu;
    logic                         down;
    logic [mrms_pkg::FIT_W-1:0]   op_a;
    logic [mrms_pkg::FIT_W-1:0]   op_b;
    logic [mrms_pkg::DIV_W:0]     up_sum;
    logic [mrms_pkg::FIT_W-1:0]   fix_fit;
    logic [mrms_pkg::GEN_W-1:0]   cgen;
    logic [mrms_pkg::MUT_W-1:0]   cmut;
    logic                         became;
    logic [2*mrms_pkg::TOTAL_W-1:0] target_prod;

    mrms_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept      = req.valid && req.ready;
    assign out_blocked = out_valid_reg && !rsp.ready;
    assign commit      = (state_reg == mrms_pkg::ST_COMMIT) && !out_blocked;
    assign req.ready   = (state_reg == mrms_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrms_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == mrms_pkg::POP_W'(mrms_pkg::POP - 1))
                    state_next = mrms_pkg::ST_IDLE;
            end
            mrms_pkg::ST_IDLE:
            begin
                if (accept && req.req_type == mrms_pkg::REQ_STEP)
                    state_next = mrms_pkg::ST_TARGET;
            end
            mrms_pkg::ST_TARGET:     state_next = mrms_pkg::ST_WALK;
            mrms_pkg::ST_WALK:
            begin
                if (rd_pend_reg && hit)
                    state_next = mrms_pkg::ST_PICK;
            end
            mrms_pkg::ST_PICK:
            begin
                state_next = mutate ? mrms_pkg::ST_MOD_GO : mrms_pkg::ST_CHILD_READ;
            end
            mrms_pkg::ST_MOD_GO:     state_next = mrms_pkg::ST_MOD_WAIT;
            mrms_pkg::ST_MOD_WAIT:
            begin
                if (div_rsp.done)
                    state_next = mrms_pkg::ST_TAB_READ;
            end
            mrms_pkg::ST_TAB_READ:   state_next = mrms_pkg::ST_EFFECT;
            mrms_pkg::ST_EFFECT:     state_next = mrms_pkg::ST_DIV_GO;
            mrms_pkg::ST_DIV_GO:     state_next = mrms_pkg::ST_DIV_WAIT;
            mrms_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = mrms_pkg::ST_FIX;
            end
            mrms_pkg::ST_FIX:        state_next = mrms_pkg::ST_CHILD_READ;
            mrms_pkg::ST_CHILD_READ: state_next = mrms_pkg::ST_COMMIT;
            mrms_pkg::ST_COMMIT:
            begin
                if (!out_blocked)
                    state_next = mrms_pkg::ST_IDLE;
            end
            default:                 state_next = mrms_pkg::ST_IDLE;
        endcase
    end

    // datapath decode
    always_comb
    begin
        cum_sum   = cum_reg + mrms_pkg::TOTAL_W'(pop_rdata_reg.fit);
        hit       = (cum_sum >= target_reg) || (rd_idx_reg == mrms_pkg::POP_W'(mrms_pkg::POP - 1));
        mutate    = {1'b0, mdraw_reg} < mut_rate_reg;
        high_sel  = pword_reg.fit >= switch_thr_reg;
        len_raw   = high_sel ? high_len_reg : low_len_reg;
        if (len_raw == '0)
            len_clamp = mrms_pkg::LEN_W'(1);
        else if (len_raw > mrms_pkg::LEN_W'(mrms_pkg::TDEPTH))
            len_clamp = mrms_pkg::LEN_W'(mrms_pkg::TDEPTH);
        else
            len_clamp = len_raw;
        eff  = high_reg ? hi_rdata_reg : lo_rdata_reg;
        neu  = high_reg ? mrms_pkg::FIT_W'(neutral_hi_reg) : mrms_pkg::FIT_W'(neutral_low_reg);
        down = eff < neu;
        if (down)
        begin
            op_a = pword_reg.fit;
            op_b = eff;
        end
        else
        begin
            op_a = (pword_reg.fit > mrms_pkg::ONE) ? pword_reg.fit - mrms_pkg::ONE
                                                   : mrms_pkg::ONE - pword_reg.fit;
            op_b = eff - neu;
        end
        if (neg_reg)
            up_sum = ({1'b0, div_rsp.quotient} > (mrms_pkg::DIV_W + 1)'(pword_reg.fit)) ? '0
                   : (mrms_pkg::DIV_W + 1)'(pword_reg.fit) - {1'b0, div_rsp.quotient};
        else
            up_sum = (mrms_pkg::DIV_W + 1)'(pword_reg.fit) + {1'b0, div_rsp.quotient};
        if (down_reg)
            fix_fit = (div_rsp.quotient > mrms_pkg::DIV_W'(mrms_pkg::FIT_MAX)) ? mrms_pkg::FIT_MAX
                    : mrms_pkg::FIT_W'(div_rsp.quotient);
        else
            fix_fit = (up_sum > (mrms_pkg::DIV_W + 1)'(mrms_pkg::FIT_MAX)) ? mrms_pkg::FIT_MAX
                    : mrms_pkg::FIT_W'(up_sum);
        cgen   = (pword_reg.gen == '1) ? pword_reg.gen : pword_reg.gen + 1'b1;
        cmut   = (mut_flag_reg && pword_reg.mut != '1) ? pword_reg.mut + 1'b1 : pword_reg.mut;
        became = mut_flag_reg && !pword_reg.rev && (cfit_reg > rev_min_reg);
        target_prod = mrms_pkg::TOTAL_W'(wheel_reg) * total_reg;
    end

    // memory and divider controls
    always_comb
    begin
        pop_raddr        = walk_addr_reg;
        pop_we           = 1'b0;
        pop_waddr        = child_reg;
        pop_wdata.fit    = cfit_reg;
        pop_wdata.gen    = cgen;
        pop_wdata.mut    = cmut;
        pop_wdata.rev    = pword_reg.rev || became;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = den_reg;
        case (state_reg)
            mrms_pkg::ST_CLEAR:
            begin
                pop_we        = 1'b1;
                pop_waddr     = clr_cnt_reg;
                pop_wdata.fit = mrms_pkg::FIT_RST;
                pop_wdata.gen = '0;
                pop_wdata.mut = '0;
                pop_wdata.rev = 1'b0;
            end
            mrms_pkg::ST_MOD_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mrms_pkg::DIV_W'(edraw_reg);
                div_req.divisor  = mrms_pkg::DEN_W'(len_clamp);
            end
            mrms_pkg::ST_DIV_GO:     div_req.start = 1'b1;
            mrms_pkg::ST_CHILD_READ: pop_raddr = child_reg;
            mrms_pkg::ST_COMMIT:
            begin
                pop_raddr = child_reg;
                pop_we    = !out_blocked;
            end
            default:                 pop_raddr = walk_addr_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop_we)
            pop_mem[pop_waddr] <= pop_wdata;
        pop_rdata_reg <= pop_mem[pop_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept && req.req_type == mrms_pkg::REQ_LOAD_LOW)
            lo_mem[req.table_slot] <= req.table_value;
        if (accept && req.req_type == mrms_pkg::REQ_LOAD_HIGH)
            hi_mem[req.table_slot] <= req.table_value;
        lo_rdata_reg <= lo_mem[div_rsp.remainder[mrms_pkg::TAB_W-1:0]];
        hi_rdata_reg <= hi_mem[div_rsp.remainder[mrms_pkg::TAB_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_thr_reg  <= mrms_pkg::FIT_W'(58982);
            neutral_low_reg <= mrms_pkg::FRAC'(5016);
            neutral_hi_reg  <= mrms_pkg::FRAC'(60495);
            mut_rate_reg    <= mrms_pkg::RATE_W'(6554);
            rev_min_reg     <= mrms_pkg::FIT_W'(65535);
            low_len_reg     <= mrms_pkg::LEN_W'(1);
            high_len_reg    <= mrms_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            case (mrms_pkg::cfg_idx_t'(cfg_index))
                mrms_pkg::CFG_SWITCH_THR:  switch_thr_reg  <= cfg_wdata[mrms_pkg::FIT_W-1:0];
                mrms_pkg::CFG_NEUTRAL_LOW: neutral_low_reg <= cfg_wdata[mrms_pkg::FRAC-1:0];
                mrms_pkg::CFG_NEUTRAL_HI:  neutral_hi_reg  <= cfg_wdata[mrms_pkg::FRAC-1:0];
                mrms_pkg::CFG_MUT_RATE:    mut_rate_reg    <= cfg_wdata[mrms_pkg::RATE_W-1:0];
                mrms_pkg::CFG_REV_MIN:     rev_min_reg     <= cfg_wdata[mrms_pkg::FIT_W-1:0];
                mrms_pkg::CFG_LOW_LEN:     low_len_reg     <= cfg_wdata[mrms_pkg::LEN_W-1:0];
                mrms_pkg::CFG_HIGH_LEN:    high_len_reg    <= cfg_wdata[mrms_pkg::LEN_W-1:0];
                default:                   low_len_reg     <= low_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrms_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            total_reg     <= mrms_pkg::TOTAL_RST;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mrms_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == mrms_pkg::ST_WALK)
                rd_pend_reg <= 1'b1;
            else
                rd_pend_reg <= 1'b0;
            if (commit)
            begin
                total_reg     <= total_reg - mrms_pkg::TOTAL_W'(pop_rdata_reg.fit)
                                 + mrms_pkg::TOTAL_W'(cfit_reg);
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wheel_reg <= req.wheel_point;
            child_reg <= req.child_index;
            mdraw_reg <= req.mutate_draw;
            edraw_reg <= req.effect_draw;
        end
        case (state_reg)
            mrms_pkg::ST_TARGET:
            begin
                target_reg    <= target_prod[mrms_pkg::TOTAL_W+mrms_pkg::DRAW_W-1:mrms_pkg::DRAW_W];
                walk_addr_reg <= '0;
                cum_reg       <= '0;
            end
            mrms_pkg::ST_WALK:
            begin
                walk_addr_reg <= walk_addr_reg + 1'b1;
                rd_idx_reg    <= walk_addr_reg;
                if (rd_pend_reg)
                begin
                    cum_reg <= cum_sum;
                    if (hit)
                    begin
                        parent_reg <= rd_idx_reg;
                        pword_reg  <= pop_rdata_reg;
                    end
                end
            end
            mrms_pkg::ST_PICK:
            begin
                high_reg     <= high_sel;
                mut_flag_reg <= mutate;
                cfit_reg     <= pword_reg.fit;
            end
            mrms_pkg::ST_EFFECT:
            begin
                prod_reg <= mrms_pkg::DIV_W'(op_a * op_b);
                den_reg  <= down ? mrms_pkg::DEN_W'(neu) : mrms_pkg::DEN_W'(mrms_pkg::ONE - neu);
                down_reg <= down;
                neg_reg  <= !down && (pword_reg.fit > mrms_pkg::ONE);
            end
            mrms_pkg::ST_FIX:        cfit_reg <= fix_fit;
            default:                 cum_reg  <= cum_reg;
        endcase
        if (commit)
        begin
            out_parent_reg <= parent_reg;
            out_child_reg  <= child_reg;
            out_fit_reg    <= cfit_reg;
            out_mut_reg    <= mut_flag_reg;
            out_became_reg <= became;
            out_rev_reg    <= pword_reg.rev || became;
            out_gen_reg    <= cgen;
            out_cnt_reg    <= cmut;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.parent_slot      = out_parent_reg;
    assign rsp.child_slot       = out_child_reg;
    assign rsp.child_fitness    = out_fit_reg;
    assign rsp.mutated          = out_mut_reg;
    assign rsp.became_revertant = out_became_reg;
    assign rsp.child_revertant  = out_rev_reg;
    assign rsp.child_generation = out_gen_reg;
    assign rsp.child_mutations  = out_cnt_reg;

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= mrms_pkg::TOTAL_MAX)
        else $error("fitness total out of range");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp.valid)
        else $error("committed step gave no item");

    a_rise_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == mrms_pkg::ST_COMMIT))
        else $error("item shown without commit");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrms_pkg::ST_CLEAR) |-> !req.ready)
        else $error("item taken during clearing pass");

endmodule

### verif/tb_moran_roulette_mutation_step_core.sv
`timescale 1ns / 100ps

module tb_moran_roulette_mutation_step_core;

    typedef struct {
        logic [mrms_pkg::POP_W-1:0] parent_slot;
        logic [mrms_pkg::POP_W-1:0] child_slot;
        logic [mrms_pkg::FIT_W-1:0] child_fitness;
        logic                       mutated;
        logic                       became_revertant;
        logic                       child_revertant;
        logic [mrms_pkg::GEN_W-1:0] child_generation;
        logic [mrms_pkg::MUT_W-1:0] child_mutations;
    } step_result_t;

    typedef struct {
        mrms_pkg::req_type_t         kind;
        logic [mrms_pkg::TAB_W-1:0]  slot;
        logic [mrms_pkg::FIT_W-1:0]  value;
        logic [mrms_pkg::DRAW_W-1:0] wheel;
        logic [mrms_pkg::POP_W-1:0]  child;
        logic [mrms_pkg::DRAW_W-1:0] mdraw;
        logic [mrms_pkg::DRAW_W-1:0] edraw;
        bit                          typed;
        logic [mrms_pkg::POP_W-1:0]  exp_parent;
        logic [mrms_pkg::FIT_W-1:0]  exp_fit;
    } request_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [mrms_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mrms_pkg::CFG_W-1:0] cfg_wdata;

    mrms_req_if req_ch ();
    mrms_rsp_if rsp_ch ();

    moran_roulette_mutation_step_core i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .req(req_ch.sink),
        .rsp(rsp_ch.source)
    );

    logic [mrms_pkg::FIT_W-1:0] fit_mem [mrms_pkg::POP];
    logic [mrms_pkg::GEN_W-1:0] gen_mem [mrms_pkg::POP];
    logic [mrms_pkg::MUT_W-1:0] mut_mem [mrms_pkg::POP];
    logic                       rev_mem [mrms_pkg::POP];
    longint unsigned            pop_total;
    logic [mrms_pkg::FIT_W-1:0] low_tab [mrms_pkg::TDEPTH];
    logic [mrms_pkg::FIT_W-1:0] high_tab [mrms_pkg::TDEPTH];
    longint unsigned  thr_reg, nlow_reg, nhigh_reg, rate_reg, revmin_reg, llen_reg, hlen_reg;

    step_result_t pending_results [$];
    int  errors;
    bit  sink_hold;
    bit  ready_free;
    longint cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic longint unsigned rescale_fitness(longint f, longint e, longint n);
        longint r;
        longint den;
        if (e < n)
            r = (f * e) / n;
        else
        begin
            den = (n < (1 << mrms_pkg::FRAC)) ? ((1 << mrms_pkg::FRAC) - n) : 1;
            r = f + (((1 << mrms_pkg::FRAC) - f) * (e - n)) / den;
        end
        if (r < 0)
            r = 0;
        if (r > (1 << mrms_pkg::FIT_W) - 1)
            r = (1 << mrms_pkg::FIT_W) - 1;
        return r;
    endfunction

    function automatic void apply_register(mrms_pkg::cfg_idx_t idx, longint unsigned v);
        case (idx)
            mrms_pkg::CFG_SWITCH_THR:  thr_reg = v & 18'h3FFFF;
            mrms_pkg::CFG_NEUTRAL_LOW: nlow_reg = v & 16'hFFFF;
            mrms_pkg::CFG_NEUTRAL_HI:  nhigh_reg = v & 16'hFFFF;
            mrms_pkg::CFG_MUT_RATE:    rate_reg = v & 17'h1FFFF;
            mrms_pkg::CFG_REV_MIN:     revmin_reg = v & 18'h3FFFF;
            mrms_pkg::CFG_LOW_LEN:     llen_reg = v & 9'h1FF;
            mrms_pkg::CFG_HIGH_LEN:    hlen_reg = v & 9'h1FF;
            default: ;
        endcase
    endfunction

    function automatic void predict_moran_step(request_t r);
        longint unsigned target, cum, pfit, cfit, len, eff, neu;
        int parent, child, idx;
        bit high, crev, became, mutd;
        logic [mrms_pkg::GEN_W-1:0] cgen;
        logic [mrms_pkg::MUT_W-1:0] cmut;
        step_result_t res;
        if (r.kind == mrms_pkg::REQ_LOAD_LOW)
        begin
            low_tab[r.slot] = r.value;
            return;
        end
        if (r.kind == mrms_pkg::REQ_LOAD_HIGH)
        begin
            high_tab[r.slot] = r.value;
            return;
        end
        if (r.kind != mrms_pkg::REQ_STEP)
            return;
        target = (longint'(r.wheel) * pop_total) >> 16;
        cum = 0;
        parent = mrms_pkg::POP - 1;
        for (int i = 0; i < mrms_pkg::POP; i++)
        begin
            cum += fit_mem[i];
            if (cum >= target)
            begin
                parent = i;
                break;
            end
        end
        child = int'(r.child);
        pfit = fit_mem[parent];
        cmut = mut_mem[parent];
        crev = rev_mem[parent];
        cfit = pfit;
        cgen = (gen_mem[parent] == '1) ? gen_mem[parent] : gen_mem[parent] + 1'b1;
        mutd = 0;
        became = 0;
        if (r.mdraw < rate_reg)
        begin
            high = pfit >= thr_reg;
            len = high ? hlen_reg : llen_reg;
            if (len < 1)
                len = 1;
            if (len > mrms_pkg::TDEPTH)
                len = mrms_pkg::TDEPTH;
            idx = int'(r.edraw % len);
            eff = high ? high_tab[idx] : low_tab[idx];
            neu = high ? nhigh_reg : nlow_reg;
            cfit = rescale_fitness(pfit, eff, neu);
            mutd = 1;
            if (cmut != '1)
                cmut++;
            if (!crev && cfit > revmin_reg)
            begin
                crev = 1;
                became = 1;
            end
        end
        pop_total = pop_total - fit_mem[child] + cfit;
        fit_mem[child] = mrms_pkg::FIT_W'(cfit);
        gen_mem[child] = cgen;
        mut_mem[child] = cmut;
        rev_mem[child] = crev;
        res.parent_slot = mrms_pkg::POP_W'(parent);
        res.child_slot = mrms_pkg::POP_W'(child);
        res.child_fitness = mrms_pkg::FIT_W'(cfit);
        res.mutated = mutd;
        res.became_revertant = became;
        res.child_revertant = crev;
        res.child_generation = cgen;
        res.child_mutations = cmut;
        if (r.typed && (res.parent_slot !== r.exp_parent || res.child_fitness !== r.exp_fit))
        begin
            $display("%0t typed row: expected parent %0d fitness %0d, predicted %0d %0d",
                     $time, r.exp_parent, r.exp_fit, res.parent_slot, res.child_fitness);
            errors++;
        end
        pending_results.insert(pending_results.size(), res);
    endfunction

    task automatic write_register(mrms_pkg::cfg_idx_t idx, longint unsigned v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= mrms_pkg::CFG_W'(v);
        apply_register(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_item(request_t r, bit gaps);
        while (gaps && $urandom_range(99) < 11)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= r.kind;
        req_ch.table_slot <= r.slot;
        req_ch.table_value <= r.value;
        req_ch.wheel_point <= r.wheel;
        req_ch.child_index <= r.child;
        req_ch.mutate_draw <= r.mdraw;
        req_ch.effect_draw <= r.edraw;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_moran_step(r);
    endtask

    task automatic drain_and_settle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (1200) @(posedge clk);
    endtask

    function automatic request_t blank_item();
        request_t r;
        r.kind = mrms_pkg::REQ_NONE;
        r.slot = '0;
        r.value = '0;
        r.wheel = '0;
        r.child = '0;
        r.mdraw = '0;
        r.edraw = '0;
        r.typed = 1'b0;
        r.exp_parent = '0;
        r.exp_fit = '0;
        return r;
    endfunction

    function automatic request_t make_load(mrms_pkg::req_type_t k, int s, int v);
        request_t r;
        r = blank_item();
        r.kind = k;
        r.slot = mrms_pkg::TAB_W'(s);
        r.value = mrms_pkg::FIT_W'(v);
        return r;
    endfunction

    function automatic request_t make_step(int w, int c, int m, int e);
        request_t r;
        r = blank_item();
        r.kind = mrms_pkg::REQ_STEP;
        r.wheel = mrms_pkg::DRAW_W'(w);
        r.child = mrms_pkg::POP_W'(c);
        r.mdraw = mrms_pkg::DRAW_W'(m);
        r.edraw = mrms_pkg::DRAW_W'(e);
        return r;
    endfunction

    function automatic request_t random_item();
        int pick;
        request_t r;
        pick = $urandom_range(99);
        if (pick < 8)
            return make_load(mrms_pkg::REQ_LOAD_LOW, $urandom_range(255), $urandom_range(262143));
        if (pick < 16)
            return make_load(mrms_pkg::REQ_LOAD_HIGH, $urandom_range(255),
                             $urandom_range(262143));
        if (pick < 19)
        begin
            r = make_step($urandom, $urandom, $urandom, $urandom);
            r.kind = mrms_pkg::REQ_NONE;
            return r;
        end
        return make_step($urandom_range(65535), $urandom_range(1023),
                         ($urandom_range(1)) ? $urandom_range(65535) : $urandom_range(8000),
                         $urandom_range(65535));
    endfunction

    always @(posedge clk)
    begin
        step_result_t e;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: parent %0d child %0d", $time,
                         rsp_ch.parent_slot, rsp_ch.child_slot);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp_ch.parent_slot !== e.parent_slot)
                begin
                    $display("%0t parent_slot exp %0d got %0d", $time,
                             e.parent_slot, rsp_ch.parent_slot);
                    errors++;
                end
                if (rsp_ch.child_slot !== e.child_slot)
                begin
                    $display("%0t child_slot exp %0d got %0d", $time,
                             e.child_slot, rsp_ch.child_slot);
                    errors++;
                end
                if (rsp_ch.child_fitness !== e.child_fitness)
                begin
                    $display("%0t child_fitness exp %0d got %0d", $time,
                             e.child_fitness, rsp_ch.child_fitness);
                    errors++;
                end
                if (rsp_ch.mutated !== e.mutated)
                begin
                    $display("%0t mutated exp %0d got %0d", $time,
                             e.mutated, rsp_ch.mutated);
                    errors++;
                end
                if (rsp_ch.became_revertant !== e.became_revertant)
                begin
                    $display("%0t became_revertant exp %0d got %0d", $time,
                             e.became_revertant, rsp_ch.became_revertant);
                    errors++;
                end
                if (rsp_ch.child_revertant !== e.child_revertant)
                begin
                    $display("%0t child_revertant exp %0d got %0d", $time,
                             e.child_revertant, rsp_ch.child_revertant);
                    errors++;
                end
                if (rsp_ch.child_generation !== e.child_generation)
                begin
                    $display("%0t child_generation exp %0d got %0d", $time,
                             e.child_generation, rsp_ch.child_generation);
                    errors++;
                end
                if (rsp_ch.child_mutations !== e.child_mutations)
                begin
                    $display("%0t child_mutations exp %0d got %0d", $time,
                             e.child_mutations, rsp_ch.child_mutations);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (sink_hold)
            rsp_ch.ready <= 1'b0;
        else if (ready_free)
            rsp_ch.ready <= 1'b1;
        else
            rsp_ch.ready <= ($urandom_range(99) >= 11);
    end

    initial
    begin
        request_t directed [$];
        request_t r;
        int limit;
        errors = 0;
        sink_hold = 0;
        ready_free = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = mrms_pkg::REQ_NONE;
        req_ch.table_slot = '0;
        req_ch.table_value = '0;
        req_ch.wheel_point = '0;
        req_ch.child_index = '0;
        req_ch.mutate_draw = '0;
        req_ch.effect_draw = '0;
        thr_reg = 58982; nlow_reg = 5016; nhigh_reg = 60495; rate_reg = 6554;
        revmin_reg = 65535; llen_reg = 1; hlen_reg = 1;
        for (int i = 0; i < mrms_pkg::POP; i++)
        begin
            fit_mem[i] = mrms_pkg::FIT_RST;
            gen_mem[i] = '0;
            mut_mem[i] = '0;
            rev_mem[i] = 1'b0;
        end
        for (int i = 0; i < mrms_pkg::TDEPTH; i++)
        begin
            low_tab[i] = '0;
            high_tab[i] = '0;
        end
        pop_total = mrms_pkg::TOTAL_RST;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: wheel zero picks slot 0, no mutation keeps fitness
        r = make_step(0, 5, 65535, 0);
        r.typed = 1; r.exp_parent = 0; r.exp_fit = 32768;
        directed.insert(directed.size(), r);
        r = make_step(65535, 1023, 65535, 65535);
        r.typed = 1; r.exp_parent = 1023; r.exp_fit = 32768;
        directed.insert(directed.size(), r);
        directed.insert(directed.size(), make_load(mrms_pkg::REQ_LOAD_LOW, 0, 0));
        directed.insert(directed.size(), make_load(mrms_pkg::REQ_LOAD_HIGH, 0, 262143));
        directed.insert(directed.size(), make_load(mrms_pkg::REQ_LOAD_LOW, 255, 262143));
        directed.insert(directed.size(), make_load(mrms_pkg::REQ_LOAD_HIGH, 255, 0));
        directed.insert(directed.size(), make_step(0, 0, 0, 0));
        directed.insert(directed.size(), make_step(32768, 1, 0, 65535));
        directed.insert(directed.size(), make_step(65535, 0, 6553, 1));
        r = make_step($urandom, $urandom, $urandom, $urandom);
        r.kind = mrms_pkg::REQ_NONE;
        directed.insert(directed.size(), r);
        directed.insert(directed.size(), make_step(12345, 512, 0, 0));
        foreach (directed[i])
            send_item(directed[i], 1'b0);
        drain_and_settle();

        for (int i = 0; i < mrms_pkg::TDEPTH; i++)
        begin
            send_item(make_load(mrms_pkg::REQ_LOAD_LOW, i, $urandom_range(262143)), 1'b1);
            send_item(make_load(mrms_pkg::REQ_LOAD_HIGH, i, $urandom_range(262143)), 1'b1);
        end
        drain_and_settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_register(mrms_pkg::CFG_SWITCH_THR, 0);
                    write_register(mrms_pkg::CFG_NEUTRAL_LOW, 1);
                    write_register(mrms_pkg::CFG_NEUTRAL_HI, 65535);
                    write_register(mrms_pkg::CFG_MUT_RATE, 65536);
                    write_register(mrms_pkg::CFG_REV_MIN, 0);
                    write_register(mrms_pkg::CFG_LOW_LEN, 256);
                    write_register(mrms_pkg::CFG_HIGH_LEN, 256);
                end
                1:
                begin
                    write_register(mrms_pkg::CFG_SWITCH_THR, 262143);
                    write_register(mrms_pkg::CFG_NEUTRAL_LOW, 65535);
                    write_register(mrms_pkg::CFG_NEUTRAL_HI, 1);
                    write_register(mrms_pkg::CFG_MUT_RATE, 0);
                    write_register(mrms_pkg::CFG_REV_MIN, 262143);
                    write_register(mrms_pkg::CFG_LOW_LEN, 1);
                    write_register(mrms_pkg::CFG_HIGH_LEN, 1);
                end
                default:
                begin
                    write_register(mrms_pkg::CFG_SWITCH_THR, $urandom_range(262143));
                    write_register(mrms_pkg::CFG_NEUTRAL_LOW, $urandom_range(65535, 1));
                    write_register(mrms_pkg::CFG_NEUTRAL_HI, $urandom_range(65535, 1));
                    write_register(mrms_pkg::CFG_MUT_RATE, $urandom_range(65536));
                    write_register(mrms_pkg::CFG_REV_MIN, $urandom_range(262143));
                    write_register(mrms_pkg::CFG_LOW_LEN, $urandom_range(256, 1));
                    write_register(mrms_pkg::CFG_HIGH_LEN, $urandom_range(256, 1));
                end
            endcase
            limit = (ph == 2) ? 16 : 10;
            ready_free = (ph == 3);
            for (int n = 0; n < limit; n++)
            begin
                if (ph == 1 && n == 2)
                    fork
                        begin
                            sink_hold = 1;
                            repeat (6000) @(posedge clk);
                            sink_hold = 0;
                        end
                    join_none
                if (n == 5)
                    drain_and_settle();
                send_item(random_item(), ph != 3);
            end
            drain_and_settle();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### moran_roulette_mutation_step_core.f
rtl/mrms_pkg.sv
rtl/mrms_if.sv
rtl/mrms_div.sv
rtl/moran_roulette_mutation_step_core.sv
verif/tb_moran_roulette_mutation_step_core.sv
